// ----- hdl/mbrs_pkg.sv -----
// Package for the Modbus RTU slave register server: types and constants.
`timescale 1ns / 1ps
package mbrs_pkg;
  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] FUNC_WRITE = 8'h06;
  localparam logic [7:0] FRAME_LEN  = 8'd8;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  typedef enum logic [3:0] {
    ST_RX, ST_RXCRC, ST_CHECK, ST_CLEAR, ST_LOAD, ST_RDWAIT, ST_SHIFT, ST_CRCLO, ST_CRCHI
  } state_t;
endpackage

// ----- hdl/mbrs_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module mbrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- hdl/modbus_rtu_slave_register_server_top.sv -----
// Top level of the Modbus RTU slave register server.
`timescale 1ns / 1ps
// Modbus RTU slave serving functions 3 (read holding registers) and 6 (write
// single register). Request bytes enter on in_* one per transfer, in_tlast on
// the final byte of a frame. The response leaves on out_* one byte per
// transfer, out_tlast on the last CRC byte. cfg_we/cfg_wdata set the slave
// address (reset 4).
// Each request byte but the last two (the received CRC) is folded into the CRC
// one bit per cycle by a serial LFSR; in_tready stays low until it is folded.
// At frame end the frame is checked; if it passes, each reply byte is produced
// and shifted through the serial CRC, then waits in the output register for
// as long as the receiver stalls. Register reads go through the RAM port, one a
// word. After reset a clearing pass writes zero to every register, one entry
// per cycle, during which no input is taken.
module modbus_rtu_slave_register_server_top #(
  parameter int REG_COUNT = 256,
  parameter int MAX_READ  = 29
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // rx_byte
  input  logic       in_tlast,   // end_of_frame
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // tx_byte
  output logic       out_tlast,  // tx_last
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import mbrs_pkg::*;
  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  state_t state_r, state_nxt;
  logic [7:0]  dev_r;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  cnt_r;
  logic        ovf_r;
  logic [7:0]  hdr_r [6];
  logic [15:0] trail_r;
  logic        eof_r;
  logic [7:0]  sh_r;
  logic [2:0]  bit_r;
  logic [AW-1:0] clr_r;
  logic [7:0]  txb_r;
  logic        tx_go_r;
  logic        ov_r, ol_r;
  logic [7:0]  od_r;
  logic [5:0]  idx_r;
  logic [5:0]  nbytes_r;
  logic        isread_r;
  logic [15:0] rd_w;
  logic        ram_we;
  logic [AW-1:0] ram_a;
  logic [15:0] ram_wd;
  logic [16:0] start_w, arg_w;
  logic        ok_w;
  logic        fb;
  logic [7:0]  next_byte;
  logic [AW-1:0] rd_a_r;

  assign start_w = {1'b0, hdr_r[2], hdr_r[3]};
  assign arg_w   = {1'b0, hdr_r[4], hdr_r[5]};

  always_comb begin
    ok_w = !ovf_r && cnt_r == FRAME_LEN && {trail_r[7:0], trail_r[15:8]} == crc_r
           && hdr_r[0] != 8'd0 && hdr_r[0] == dev_r;
    if (hdr_r[1] == FUNC_READ)
      ok_w = ok_w && arg_w != 17'd0 && arg_w <= 17'(MAX_READ)
             && start_w + arg_w <= 17'(REG_COUNT);
    else if (hdr_r[1] == FUNC_WRITE)
      ok_w = ok_w && start_w < 17'(REG_COUNT);
    else
      ok_w = 1'b0;
  end

  mbrs_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wd), .rdata(rd_w));

  always_comb begin
    ram_we = 1'b0;
    ram_a  = rd_a_r;
    ram_wd = {hdr_r[4], hdr_r[5]};
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1; ram_a = clr_r; ram_wd = 16'd0;
    end else if (state_r == ST_CHECK && ok_w && hdr_r[1] == FUNC_WRITE) begin
      ram_we = 1'b1; ram_a = AW'(start_w);
    end
  end

  assign fb = crc_r[0] ^ sh_r[0];
  assign crc_nxt = fb ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);

  always_comb begin
    next_byte = 8'd0;
    if (isread_r) begin
      if (idx_r == 6'd0) next_byte = dev_r;
      else if (idx_r == 6'd1) next_byte = FUNC_READ;
      else if (idx_r == 6'd2) next_byte = {hdr_r[5][6:0], 1'b0};
      else if (idx_r[0]) next_byte = rd_w[15:8];
      else next_byte = rd_w[7:0];
    end else begin
      case (idx_r)
        6'd0: next_byte = dev_r;
        6'd1: next_byte = FUNC_WRITE;
        6'd2: next_byte = hdr_r[2];
        6'd3: next_byte = hdr_r[3];
        6'd4: next_byte = hdr_r[4];
        6'd5: next_byte = hdr_r[5];
        default: next_byte = 8'd0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_r == AW'(REG_COUNT - 1)) state_nxt = ST_RX;
      ST_RX:     if (in_tvalid) state_nxt = ST_RXCRC;
      ST_RXCRC:  if (bit_r == 3'd7) state_nxt = eof_r ? ST_CHECK : ST_RX;
      ST_CHECK:  state_nxt = ok_w ? ST_RDWAIT : ST_RX;
      ST_RDWAIT: state_nxt = ST_LOAD;
      ST_LOAD:   if (!ov_r) state_nxt = ST_SHIFT;
      ST_SHIFT:  if (bit_r == 3'd7)
                   state_nxt = (idx_r == nbytes_r - 6'd1) ? ST_CRCLO : ST_RDWAIT;
      ST_CRCLO:  if (!ov_r) state_nxt = ST_CRCHI;
      ST_CRCHI:  if (!ov_r) state_nxt = ST_RX;
      default:   state_nxt = ST_RX;
    endcase
  end

  assign in_tready  = state_r == ST_RX;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      dev_r <= 8'd4;
      crc_r <= CRC_INIT;
      cnt_r <= 8'd0;
      ovf_r <= 1'b0;
      trail_r <= 16'd0;
      for (int i = 0; i < 6; i++) hdr_r[i] <= 8'd0;
      clr_r <= '0;
      bit_r <= 3'd0;
      ov_r <= 1'b0;
      tx_go_r <= 1'b0;
      idx_r <= 6'd0;
      eof_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) dev_r <= cfg_wdata;
      if (ov_r && out_tready) ov_r <= 1'b0;
      case (state_r)
        ST_CLEAR: clr_r <= clr_r + AW'(1);
        ST_RX: if (in_tvalid) begin
          if (cnt_r < 8'd6) hdr_r[cnt_r[2:0]] <= in_tdata;
          sh_r <= trail_r[15:8];
          tx_go_r <= cnt_r >= 8'd2;
          trail_r <= {trail_r[7:0], in_tdata};
          if (cnt_r == 8'd255) ovf_r <= 1'b1; else cnt_r <= cnt_r + 8'd1;
          eof_r <= in_tlast;
          bit_r <= 3'd0;
        end
        ST_RXCRC: begin
          if (tx_go_r) begin crc_r <= crc_nxt; sh_r <= sh_r >> 1; end
          bit_r <= bit_r + 3'd1;
        end
        ST_CHECK: begin
          isread_r <= hdr_r[1] == FUNC_READ;
          nbytes_r <= (hdr_r[1] == FUNC_READ) ? (hdr_r[5][5:0] << 1) + 6'd3 : 6'd6;
          rd_a_r <= AW'(start_w);
          idx_r <= 6'd0;
          crc_r <= CRC_INIT;
          cnt_r <= 8'd0; ovf_r <= 1'b0; trail_r <= 16'd0;
          if (!ok_w) begin
            for (int i = 0; i < 6; i++) hdr_r[i] <= 8'd0;
          end
        end
        ST_LOAD: if (!ov_r) begin
          sh_r <= next_byte; txb_r <= next_byte; bit_r <= 3'd0;
        end
        ST_SHIFT: begin
          crc_r <= crc_nxt; sh_r <= sh_r >> 1; bit_r <= bit_r + 3'd1;
          if (bit_r == 3'd7) begin
            ov_r <= 1'b1; od_r <= txb_r; ol_r <= 1'b0;
            idx_r <= idx_r + 6'd1;
            if (isread_r && idx_r >= 6'd4 && !idx_r[0]) rd_a_r <= rd_a_r + AW'(1);
          end
        end
        ST_CRCLO: if (!ov_r) begin ov_r <= 1'b1; od_r <= crc_r[7:0]; ol_r <= 1'b0; end
        ST_CRCHI: if (!ov_r) begin
          ov_r <= 1'b1; od_r <= crc_r[15:8]; ol_r <= 1'b1;
          crc_r <= CRC_INIT;
          for (int i = 0; i < 6; i++) hdr_r[i] <= 8'd0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- tb/testbench.sv -----
// Testbench for the Modbus RTU slave register server: directed and random frames checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import mbrs_pkg::*;

  class reply_board;
    logic [15:0] regs [256];
    logic [7:0]  slave_addr;
    logic [15:0] crc;
    logic [7:0]  cnt;
    logic [7:0]  hdr [6];
    logic [15:0] tail;
    bit          ovf;
    logic [8:0]  pending [$];
    int          errors;
    int          replies;

    function new();
      foreach (regs[i]) regs[i] = '0;
      slave_addr = 8'd4;
      errors = 0;
      replies = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      crc = CRC_INIT;
      cnt = '0;
      foreach (hdr[i]) hdr[i] = '0;
      tail = '0;
      ovf = 0;
    endfunction

    static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      c ^= {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void emit(ref logic [15:0] c, input logic [7:0] b);
      pending.push_back({1'b0, b});
      c = crc_byte(c, b);
    endfunction

    function void note_request(logic [7:0] b, bit eof);
      logic [15:0] rc, recv;
      logic [16:0] addr, arg;
      if (cnt < 6) hdr[cnt[2:0]] = b;
      if (cnt >= 2) crc = crc_byte(crc, tail[15:8]);
      tail = {tail[7:0], b};
      if (cnt == 8'd255) ovf = 1; else cnt++;
      if (!eof) return;
      rc = CRC_INIT;
      recv = {tail[7:0], tail[15:8]};
      addr = {hdr[2], hdr[3]};
      arg = {hdr[4], hdr[5]};
      if (!ovf && cnt == FRAME_LEN && recv == crc && hdr[0] != 0 && hdr[0] == slave_addr) begin
        if (hdr[1] == FUNC_READ && arg != 0 && arg <= 29 && addr + arg <= 256) begin
          emit(rc, slave_addr);
          emit(rc, FUNC_READ);
          emit(rc, 8'(arg * 2));
          for (int j = 0; j < arg; j++) begin
            emit(rc, regs[addr + j][15:8]);
            emit(rc, regs[addr + j][7:0]);
          end
          pending.push_back({1'b0, rc[7:0]});
          pending.push_back({1'b1, rc[15:8]});
          replies++;
        end else if (hdr[1] == FUNC_WRITE && addr < 256) begin
          regs[addr] = arg[15:0];
          emit(rc, slave_addr);
          emit(rc, FUNC_WRITE);
          for (int j = 2; j < 6; j++) emit(rc, hdr[j]);
          pending.push_back({1'b0, rc[7:0]});
          pending.push_back({1'b1, rc[15:8]});
          replies++;
        end
      end
      clear_frame();
    endfunction

    function void check_byte(logic [7:0] d, logic l);
      logic [8:0] e;
      if (pending.size() == 0) begin
        $error("unexpected transfer tx_byte=%h tx_last=%b", d, l);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d !== e[7:0]) begin
        $error("tx_byte expected %h actual %h", e[7:0], d);
        errors++;
      end
      if (l !== e[8]) begin
        $error("tx_last expected %b actual %b", e[8], l);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tlast = 0, out_tready = 0, cfg_we = 0;
  logic [7:0] in_tdata = 0, cfg_wdata = 0;
  logic in_tready, out_tvalid, out_tlast;
  logic [7:0] out_tdata;
  reply_board sb = new();
  bit calm = 0;
  int idle_cycles = 0;
  int sent = 0;

  always #4 clk = ~clk;

  modbus_rtu_slave_register_server_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("modbus_rtu_slave_register_server_top verification failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      out_tready <= 1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk);
      if (!calm && $urandom_range(0, 1)) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic eof);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= b;
    in_tlast <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(b, eof);
    sent++;
  endtask

  task automatic send_frame(logic [7:0] f [$], bit good_crc);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (f[i]) c = reply_board::crc_byte(c, f[i]);
    if (!good_crc) c ^= 16'(1 << $urandom_range(0, 15));
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  task automatic request(logic [7:0] a, logic [7:0] fn, logic [15:0] p1, logic [15:0] p2,
                         bit good_crc = 1);
    logic [7:0] f [$];
    f = '{a, fn, p1[15:8], p1[7:0], p2[15:8], p2[7:0]};
    send_frame(f, good_crc);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    in_tlast <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_address(logic [7:0] a);
    drain();
    cfg_we <= 1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 0;
    sb.slave_addr = a;
  endtask

  task automatic random_frame();
    int k;
    logic [7:0] f [$];
    logic [7:0] a;
    k = $urandom_range(0, 99);
    a = ($urandom_range(0, 9) == 0) ? 8'($urandom) : sb.slave_addr;
    if (k < 40)
      request(a, FUNC_WRITE, $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 255)),
              16'($urandom), $urandom_range(0, 9) != 0);
    else if (k < 80)
      request(a, FUNC_READ, 16'($urandom_range(0, 250)),
              $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(1, 6)),
              $urandom_range(0, 9) != 0);
    else if (k < 90)
      request(a, 8'($urandom), 16'($urandom), 16'($urandom));
    else begin
      repeat ($urandom_range(1, 12)) f.push_back(8'($urandom));
      send_frame(f, 1);
    end
  endtask

  initial begin
    logic [7:0] f [$];
    repeat (4) @(posedge clk);
    rst_n <= 1;
    request(8'd4, FUNC_READ, 16'd0, 16'd3);
    request(8'd4, FUNC_WRITE, 16'd0, 16'hFFFF);
    request(8'd4, FUNC_WRITE, 16'd255, 16'hA5A5);
    request(8'd4, FUNC_WRITE, 16'd256, 16'h1234);
    request(8'd4, FUNC_READ, 16'd0, 16'd29);
    request(8'd4, FUNC_READ, 16'd227, 16'd29);
    request(8'd4, FUNC_READ, 16'd228, 16'd29);
    request(8'd4, FUNC_READ, 16'd0, 16'd30);
    request(8'd4, FUNC_READ, 16'd5, 16'd0);
    request(8'd4, FUNC_READ, 16'hFFFF, 16'hFFFF);
    request(8'd4, FUNC_WRITE, 16'd1, 16'h5A5A, 0);
    request(8'd0, FUNC_WRITE, 16'd2, 16'h0001);
    request(8'd5, FUNC_WRITE, 16'd2, 16'h0001);
    request(8'd4, 8'h10, 16'd2, 16'h0001);
    f = '{8'd4, FUNC_READ, 8'd0};
    send_frame(f, 1);
    request(8'd4, FUNC_READ, 16'd254, 16'd2);
    set_address(8'd247);
    request(8'd247, FUNC_WRITE, 16'd7, 16'h00FF);
    set_address(8'd0);
    request(8'd0, FUNC_READ, 16'd0, 16'd1);
    set_address(8'd1);
    request(8'd1, FUNC_READ, 16'd0, 16'd8);
    for (int i = 0; i < 5; i++) begin
      if (i == 2) set_address(8'($urandom_range(1, 247)));
      if (i == 3) calm = 1;
      random_frame();
    end
    drain();
    $display("Sent %0d request bytes; %0d replies over reads, writes, bad CRC, wrong",
             sent, sb.replies);
    $display("addresses, codes, short and long frames and address changes.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("modbus_rtu_slave_register_server_top verification clean");
    end else begin
      $display("modbus_rtu_slave_register_server_top verification failed");
    end
    $finish;
  end
endmodule

// ----- modbus_rtu_slave_register_server_top.f -----
hdl/mbrs_pkg.sv
hdl/mbrs_ram.sv
hdl/modbus_rtu_slave_register_server_top.sv
tb/testbench.sv
